[rtl/core/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EW        = 18;
    localparam int NELEM     = 9;
    localparam int RW        = EW + 3;
    localparam int RTW       = 18;
    localparam int VW        = 2 * RTW;
    localparam int DW        = EW + 1;
    localparam int NW        = 36;
    localparam int QB        = 27;
    localparam int NLANE     = 3;

    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } t_sel;

    typedef struct packed {
        t_sel                 sel;
        logic                 bad;
        logic signed [DW-1:0] d0;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
    } t_ctx;

endpackage

[rtl/core/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to quaternion stream pipeline.
// Order: prep register, root pipeline, divider pipeline, output register.
// Throughput: one transaction per cycle; the whole pipeline holds while the output waits.
// The root pipeline has 18 stages and the three-lane divider pipeline has 27 division steps.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data needs no reset.
module rotation_matrix_to_quaternion (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), zero pad
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z (18 bits each)
    output logic [71:0]  m_axis_tdata,
    // bad_input
    output logic         m_axis_tuser
);

    localparam int EW = rmq_pkg::EW;
    localparam int QB = rmq_pkg::QB;

    logic                    en;
    logic                    p_valid;
    logic [rmq_pkg::VW-1:0]  p_v;
    rmq_pkg::t_ctx           p_ctx;
    logic                    s_valid;
    logic [rmq_pkg::RTW-1:0] s_root;
    rmq_pkg::t_ctx           s_ctx;
    logic                    d_valid;
    logic [QB-1:0]           d_q [0:rmq_pkg::NLANE-1];
    logic [rmq_pkg::RTW-1:0] d_root;
    rmq_pkg::t_ctx           d_ctx;
    logic [EW-1:0]           c  [0:rmq_pkg::NLANE-1];
    logic [EW-1:0]           big;
    logic [rmq_pkg::RTW:0]   bigw;
    logic [4*EW-1:0]         n_data;
    logic                    sg [0:rmq_pkg::NLANE-1];
    logic                    r_ovalid;
    logic [4*EW-1:0]         r_odata;
    logic                    r_ouser;

    assign en            = !r_ovalid || m_axis_tready;
    assign s_axis_tready = en;

    rmq_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata[rmq_pkg::NELEM*EW-1:0]),
        .o_valid (p_valid),
        .o_v     (p_v),
        .o_ctx   (p_ctx)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_v     (p_v),
        .i_ctx   (p_ctx),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_ctx   (s_ctx)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_ctx   (s_ctx),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_root  (d_root),
        .o_ctx   (d_ctx)
    );

    always_comb begin
        sg[0] = d_ctx.d0[rmq_pkg::DW-1];
        sg[1] = d_ctx.d1[rmq_pkg::DW-1];
        sg[2] = d_ctx.d2[rmq_pkg::DW-1];
        for (int l = 0; l < rmq_pkg::NLANE; l++) begin
            if (sg[l]) begin
                if (d_q[l] > QB'(1 << (EW-1))) c[l] = {1'b1, {(EW-1){1'b0}}};
                else                           c[l] = EW'(-d_q[l]);
            end else begin
                if (d_q[l] > QB'((1 << (EW-1)) - 1)) c[l] = {1'b0, {(EW-1){1'b1}}};
                else                                 c[l] = EW'(d_q[l]);
            end
        end
        bigw = ({1'b0, d_root} + 1'b1) >> 1;
        big  = EW'(bigw);
        case (d_ctx.sel)
            rmq_pkg::SEL_W: n_data = {c[2], c[1], c[0], big};
            rmq_pkg::SEL_X: n_data = {c[2], c[1], big, c[0]};
            rmq_pkg::SEL_Y: n_data = {c[2], big, c[1], c[0]};
            rmq_pkg::SEL_Z: n_data = {big, c[2], c[1], c[0]};
            default:        n_data = '0;
        endcase
        if (d_ctx.bad) n_data = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata <= n_data;
            r_ouser <= d_ctx.bad;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

[rtl/core/rmq_prep.sv]
// Input stage: trace, branch select, radicand and off-diagonal sums and differences.
module rmq_prep (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [rmq_pkg::NELEM*rmq_pkg::EW-1:0]  i_data,
    output logic                                   o_valid,
    output logic [rmq_pkg::VW-1:0]                 o_v,
    output rmq_pkg::t_ctx                          o_ctx
);

    logic signed [rmq_pkg::DW-1:0] a [0:rmq_pkg::NELEM-1];
    logic signed [rmq_pkg::RW-1:0] w [0:rmq_pkg::NELEM-1];
    logic signed [rmq_pkg::RW-1:0] trace;
    logic signed [rmq_pkg::RW-1:0] rad;
    logic signed [rmq_pkg::RW-1:0] one;
    rmq_pkg::t_ctx                 ctx;
    logic [rmq_pkg::VW-1:0]        v;
    logic                          r_valid;
    logic [rmq_pkg::VW-1:0]        r_v;
    rmq_pkg::t_ctx                 r_ctx;

    always_comb begin
        for (int k = 0; k < rmq_pkg::NELEM; k++) begin
            a[k] = rmq_pkg::DW'($signed(i_data[k*rmq_pkg::EW +: rmq_pkg::EW]));
            w[k] = rmq_pkg::RW'($signed(i_data[k*rmq_pkg::EW +: rmq_pkg::EW]));
        end
        one   = rmq_pkg::RW'(1 << rmq_pkg::FRAC_BITS);
        trace = w[0] + w[4] + w[8];
        ctx   = '0;
        if (trace > 0) begin
            ctx.sel = rmq_pkg::SEL_W;
            rad     = one + trace;
            ctx.d0  = a[7] - a[5];
            ctx.d1  = a[2] - a[6];
            ctx.d2  = a[3] - a[1];
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            ctx.sel = rmq_pkg::SEL_X;
            rad     = one + w[0] - w[4] - w[8];
            ctx.d0  = a[7] - a[5];
            ctx.d1  = a[1] + a[3];
            ctx.d2  = a[2] + a[6];
        end else if (a[4] > a[8]) begin
            ctx.sel = rmq_pkg::SEL_Y;
            rad     = one + w[4] - w[0] - w[8];
            ctx.d0  = a[2] - a[6];
            ctx.d1  = a[1] + a[3];
            ctx.d2  = a[5] + a[7];
        end else begin
            ctx.sel = rmq_pkg::SEL_Z;
            rad     = one + w[8] - w[0] - w[4];
            ctx.d0  = a[3] - a[1];
            ctx.d1  = a[2] + a[6];
            ctx.d2  = a[5] + a[7];
        end
        ctx.bad = (rad <= 0);
        v = ctx.bad ? '0
                    : rmq_pkg::VW'({rad[rmq_pkg::RW-2:0], {rmq_pkg::FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= v;
            r_ctx <= ctx;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_ctx   = r_ctx;

endmodule

[rtl/core/rmq_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [rmq_pkg::VW-1:0]  i_v,
    input  rmq_pkg::t_ctx           i_ctx,
    output logic                    o_valid,
    output logic [rmq_pkg::RTW-1:0] o_root,
    output rmq_pkg::t_ctx           o_ctx
);

    localparam int RMW = rmq_pkg::RTW + 2;

    logic                    r_vld  [0:rmq_pkg::RTW-1];
    logic [rmq_pkg::VW-1:0]  r_v    [0:rmq_pkg::RTW-1];
    logic [RMW-1:0]          r_rem  [0:rmq_pkg::RTW-1];
    logic [rmq_pkg::RTW-1:0] r_root [0:rmq_pkg::RTW-1];
    rmq_pkg::t_ctx           r_ctx  [0:rmq_pkg::RTW-1];
    logic                    n_vld  [0:rmq_pkg::RTW-1];
    logic [rmq_pkg::VW-1:0]  n_v    [0:rmq_pkg::RTW-1];
    logic [RMW-1:0]          n_rem  [0:rmq_pkg::RTW-1];
    logic [rmq_pkg::RTW-1:0] n_root [0:rmq_pkg::RTW-1];
    rmq_pkg::t_ctx           n_ctx  [0:rmq_pkg::RTW-1];

    always_comb begin
        logic [rmq_pkg::VW-1:0]  pv;
        logic [RMW-1:0]          prem;
        logic [rmq_pkg::RTW-1:0] proot;
        logic [RMW-1:0]          cat;
        logic [RMW-1:0]          trial;
        for (int k = 0; k < rmq_pkg::RTW; k++) begin
            if (k == 0) begin
                pv       = i_v;
                prem     = '0;
                proot    = '0;
                n_vld[k] = i_valid;
                n_ctx[k] = i_ctx;
            end else begin
                pv       = r_v[k-1];
                prem     = r_rem[k-1];
                proot    = r_root[k-1];
                n_vld[k] = r_vld[k-1];
                n_ctx[k] = r_ctx[k-1];
            end
            cat   = {prem[RMW-3:0], pv[rmq_pkg::VW-1 -: 2]};
            trial = {proot, 2'b01};
            n_v[k] = {pv[rmq_pkg::VW-3:0], 2'b00};
            if (cat >= trial) begin
                n_rem[k]  = cat - trial;
                n_root[k] = {proot[rmq_pkg::RTW-2:0], 1'b1};
            end else begin
                n_rem[k]  = cat;
                n_root[k] = {proot[rmq_pkg::RTW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rmq_pkg::RTW; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < rmq_pkg::RTW; k++) r_vld[k] <= n_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < rmq_pkg::RTW; k++) begin
                r_v[k]    <= n_v[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_ctx[k]  <= n_ctx[k];
            end
        end
    end

    assign o_valid = r_vld[rmq_pkg::RTW-1];
    assign o_root  = r_root[rmq_pkg::RTW-1];
    assign o_ctx   = r_ctx[rmq_pkg::RTW-1];

endmodule

[rtl/core/rmq_div.sv]
// Pipelined three-lane restoring divider, rounded |d| / (2*root), one bit per stage after the first.
module rmq_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [rmq_pkg::RTW-1:0] i_root,
    input  rmq_pkg::t_ctx           i_ctx,
    output logic                    o_valid,
    output logic [rmq_pkg::QB-1:0]  o_q [0:rmq_pkg::NLANE-1],
    output logic [rmq_pkg::RTW-1:0] o_root,
    output rmq_pkg::t_ctx           o_ctx
);

    localparam int NS = rmq_pkg::QB + 1;
    localparam int DW = rmq_pkg::DW;
    localparam int QB = rmq_pkg::QB;
    localparam int NL = rmq_pkg::NLANE;

    logic                    r_vld  [0:NS-1];
    logic [DW-1:0]           r_den  [0:NS-1];
    logic [rmq_pkg::RTW-1:0] r_root [0:NS-1];
    rmq_pkg::t_ctx           r_ctx  [0:NS-1];
    logic [DW-1:0]           r_rem  [0:NS-1][0:NL-1];
    logic [QB-1:0]           r_nl   [0:NS-1][0:NL-1];
    logic [QB-1:0]           r_q    [0:NS-1][0:NL-1];
    logic [DW-1:0]           n_rem  [0:NS-1][0:NL-1];
    logic [QB-1:0]           n_nl   [0:NS-1][0:NL-1];
    logic [QB-1:0]           n_q    [0:NS-1][0:NL-1];
    logic signed [DW-1:0]    d      [0:NL-1];

    always_comb begin
        logic [DW-1:0]           mag;
        logic [rmq_pkg::NW-1:0]  num;
        logic [DW:0]             cat;
        d[0] = i_ctx.d0;
        d[1] = i_ctx.d1;
        d[2] = i_ctx.d2;
        for (int l = 0; l < NL; l++) begin
            mag = d[l][DW-1] ? DW'(-d[l]) : DW'(d[l]);
            num = rmq_pkg::NW'({mag, {rmq_pkg::FRAC_BITS{1'b0}}})
                + rmq_pkg::NW'(i_root);
            n_rem[0][l] = DW'(num[rmq_pkg::NW-1:QB]);
            n_nl[0][l]  = num[QB-1:0];
            n_q[0][l]   = '0;
        end
        for (int k = 1; k < NS; k++) begin
            for (int l = 0; l < NL; l++) begin
                cat = {r_rem[k-1][l], r_nl[k-1][l][QB-1]};
                n_nl[k][l] = {r_nl[k-1][l][QB-2:0], 1'b0};
                if (cat >= {1'b0, r_den[k-1]}) begin
                    n_rem[k][l] = DW'(cat - {1'b0, r_den[k-1]});
                    n_q[k][l]   = {r_q[k-1][l][QB-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = cat[DW-1:0];
                    n_q[k][l]   = {r_q[k-1][l][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= {i_root, 1'b0};
            r_root[0] <= i_root;
            r_ctx[0]  <= i_ctx;
            for (int k = 1; k < NS; k++) begin
                r_den[k]  <= r_den[k-1];
                r_root[k] <= r_root[k-1];
                r_ctx[k]  <= r_ctx[k-1];
            end
            for (int k = 0; k < NS; k++) begin
                for (int l = 0; l < NL; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_nl[k][l]  <= n_nl[k][l];
                    r_q[k][l]   <= n_q[k][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) o_q[l] = r_q[NS-1][l];
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_ctx   = r_ctx[NS-1];

endmodule
